// ===== sv/mvn_pkg.sv =====
// Shared types and constants for the mesh vertex normal block.
package mvn_pkg;

    localparam int IDX_W = 10;
    localparam int COORD_W = 32;
    localparam int NORM_W = 16;
    localparam int UNIT_Q14 = 16384;

    // Item kinds as coded on the func port.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // Result kinds.
    typedef enum logic {
        KIND_FACE   = 1'b0,
        KIND_VERTEX = 1'b1
    } kind_t;

    // One classified command as held in the queue.
    typedef struct packed {
        op_t                              op;
        logic [2:0]                       in_range;
        logic [2:0][IDX_W-1:0]            idx;
        logic signed [COORD_W-1:0]        x;
        logic signed [COORD_W-1:0]        y;
        logic signed [COORD_W-1:0]        z;
    } cmd_t;

    // Normaliser result, done is a one-cycle strobe.
    typedef struct packed {
        logic                      done;
        logic                      zero;
        logic signed [NORM_W-1:0]  x;
        logic signed [NORM_W-1:0]  y;
        logic signed [NORM_W-1:0]  z;
    } norm_res_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_REDUCE,
        N_SQUARE,
        N_SQRT,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_LOAD,
        B_FETCH,
        B_EDGE,
        B_CROSS,
        B_READ,
        B_NORM,
        B_ACC
    } back_state_t;

endpackage

// ===== sv/mvn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mvn_front.sv =====
// Command front end: accepts beats, classifies them and queues them for the back end.
module mvn_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               hold,
    input  logic [1:0]                         func,
    input  logic [mvn_pkg::IDX_W-1:0]          index_a,
    input  logic [mvn_pkg::IDX_W-1:0]          index_b,
    input  logic [mvn_pkg::IDX_W-1:0]          index_c,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_x,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_y,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_z,
    input  logic                               pop,
    output logic                               busy,
    output logic                               cmd_valid,
    output mvn_pkg::cmd_t                      cmd
);
    import mvn_pkg::*;

    localparam logic [31:0] MAXV = 32'(MAX_VERTICES);

    cmd_t       q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg, count_next;
    logic       accept;
    cmd_t       new_cmd;

    assign busy = (count_reg == 2'd2) || hold;
    assign accept = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd = q_reg[rd_reg];

    // Classify the beat: decode the kind and range-check the three indexes.
    always_comb
    begin
        new_cmd.op = op_t'(func);
        new_cmd.idx = {index_c, index_b, index_a};
        new_cmd.in_range[0] = 32'(index_a) < MAXV;
        new_cmd.in_range[1] = 32'(index_b) < MAXV;
        new_cmd.in_range[2] = 32'(index_c) < MAXV;
        new_cmd.x = coord_x;
        new_cmd.y = coord_y;
        new_cmd.z = coord_z;
    end

    always_comb
    begin
        count_next = count_reg + 2'(accept) - 2'(pop);
    end

    // Two-entry queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_reg] <= new_cmd;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue overfilled");

endmodule

// ===== sv/mvn_norm.sv =====
// Iterative normaliser: range reduction, sum of squares, square root and three divisions.
module mvn_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0][63:0] vin,
    output mvn_pkg::norm_res_t res
);
    import mvn_pkg::*;

    norm_state_t              state_reg, state_next;
    logic [2:0][62:0]         m_reg;
    logic [2:0]               neg_reg;
    logic [5:0]               cnt_reg;
    logic [61:0]              prod_reg;
    logic [63:0]              sum_reg, x_reg, root_reg, one_reg;
    logic [47:0]              rem_reg, dvs_reg;
    logic [15:0]              quo_reg;
    logic [1:0]               comp_reg;
    logic [2:0][NORM_W-1:0]   n_reg;
    logic                     zero_reg;

    logic [2:0][62:0] mag_in;
    logic             over;
    logic [30:0]      sq_op;
    logic [63:0]      sqrt_t;
    logic             sqrt_ge;
    logic             div_ge;
    logic [62:0]      m_sel;
    logic             neg_sel;
    logic [15:0]      q_clamp;
    logic [NORM_W-1:0] q_signed;

    // Magnitudes of the incoming vector.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vin[i][63] ? 63'(-vin[i]) : vin[i][62:0];
        end
    end

    assign over = |(m_reg[0][62:31] | m_reg[1][62:31] | m_reg[2][62:31]);

    // Operand for the squaring step.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0: sq_op = m_reg[0][30:0];
            2'd1: sq_op = m_reg[1][30:0];
            2'd2: sq_op = m_reg[2][30:0];
            default: sq_op = 31'd0;
        endcase
    end

    // Component under division.
    always_comb
    begin
        case (comp_reg)
            2'd0: begin m_sel = m_reg[0]; neg_sel = neg_reg[0]; end
            2'd1: begin m_sel = m_reg[1]; neg_sel = neg_reg[1]; end
            default: begin m_sel = m_reg[2]; neg_sel = neg_reg[2]; end
        endcase
    end

    assign sqrt_t = root_reg + one_reg;
    assign sqrt_ge = x_reg >= sqrt_t;
    assign div_ge = rem_reg >= dvs_reg;
    assign q_clamp = (quo_reg > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : quo_reg;
    assign q_signed = neg_sel ? -q_clamp : q_clamp;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:   if (start) state_next = N_REDUCE;
            N_REDUCE: if (!over) state_next = N_SQUARE;
            N_SQUARE:
            begin
                if (cnt_reg == 6'd4)
                begin
                    state_next = (sum_reg == 64'd0) ? N_DONE : N_SQRT;
                end
            end
            N_SQRT:   if (cnt_reg == 6'd31) state_next = N_DIV;
            N_DIV:    if (cnt_reg == 6'd17 && comp_reg == 2'd2) state_next = N_DONE;
            N_DONE:   state_next = N_IDLE;
            default:  state_next = N_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        res.done = (state_reg == N_DONE);
        res.zero = zero_reg;
        res.x = n_reg[0];
        res.y = n_reg[1];
        res.z = n_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg || (state_reg == N_DIV && cnt_reg == 6'd17))
            begin
                cnt_reg <= 6'd0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    // Datapath, one step per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= mag_in[i];
                    neg_reg[i] <= vin[i][63];
                end
                zero_reg <= 1'b0;
                comp_reg <= 2'd0;
                sum_reg <= 64'd0;
                prod_reg <= 62'd0;
            end
            N_REDUCE:
            begin
                // Halve every magnitude while the largest is 2^31 or more.
                if (over)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
            end
            N_SQUARE:
            begin
                sum_reg <= sum_reg + 64'(prod_reg);
                prod_reg <= sq_op * sq_op;
                if (cnt_reg == 6'd4)
                begin
                    zero_reg <= (sum_reg == 64'd0);
                    n_reg <= '0;
                    x_reg <= sum_reg;
                    root_reg <= 64'd0;
                    one_reg <= 64'd1 << 62;
                end
            end
            N_SQRT:
            begin
                if (sqrt_ge)
                begin
                    x_reg <= x_reg - sqrt_t;
                    root_reg <= (root_reg >> 1) + one_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            N_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    // Rounded numerator and divisor aligned for sixteen quotient bits.
                    rem_reg <= 48'({m_sel[30:0], 14'd0}) + 48'(root_reg[31:1]);
                    dvs_reg <= {1'b0, root_reg[31:0], 15'd0};
                    quo_reg <= 16'd0;
                end
                else if (cnt_reg == 6'd17)
                begin
                    n_reg[comp_reg] <= q_signed;
                    comp_reg <= comp_reg + 2'd1;
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    quo_reg <= {quo_reg[14:0], div_ge};
                    dvs_reg <= dvs_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/mvn_back.sv =====
// Command back end: vertex stores, cross product, normaliser and accumulator updates.
module mvn_back #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  mvn_pkg::cmd_t                   cmd,
    output logic                            pop,
    output logic                            init_busy,
    output logic                            done,
    output logic                            result_kind,
    output logic signed [mvn_pkg::NORM_W-1:0] normal_x,
    output logic signed [mvn_pkg::NORM_W-1:0] normal_y,
    output logic signed [mvn_pkg::NORM_W-1:0] normal_z,
    output logic                            zero_length
);
    import mvn_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg;
    logic [2:0]        cnt_reg;
    logic [AW-1:0]     sweep_reg;
    logic              init_reg;
    logic signed [31:0] p_reg [3][3];
    logic [2:0][30:0]  ea_reg, eb_reg;
    logic signed [61:0] prod_reg;
    logic signed [63:0] cross_reg [3];
    logic              done_reg, kind_reg, zl_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;

    logic              pos_we, acc_we, norm_start;
    logic [AW-1:0]     pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [95:0]       pos_wdata, pos_rdata, acc_wdata, acc_rdata;
    logic [1:0]        sel;
    logic [IDX_W-1:0]  idx_sel;
    logic              rng_sel;
    logic [1:0]        cap_sel;
    logic              rng_cap;
    logic [2:0][32:0]  da, db;
    logic signed [30:0] op_a, op_b;
    logic [2:0][63:0]  vin;
    norm_res_t         nres;

    function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i);
        return w[AW-1:0];
    endfunction

    // Bring an edge into 31-bit signed range by a common right shift of the magnitudes.
    function automatic logic [2:0][30:0] reduce_edge(logic [2:0][32:0] d);
        logic [2:0][32:0] mg;
        logic [32:0]      all;
        logic [1:0]       sh;
        logic [32:0]      r;
        logic [2:0][30:0] o;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = d[i][32] ? -d[i] : d[i];
        end
        all = mg[0] | mg[1] | mg[2];
        sh = all[32] ? 2'd3 : (all[31] ? 2'd2 : (all[30] ? 2'd1 : 2'd0));
        for (int i = 0; i < 3; i++)
        begin
            r = mg[i] >> sh;
            o[i] = d[i][32] ? 31'(-r) : r[30:0];
        end
        return o;
    endfunction

    function automatic logic [31:0] sat_add(logic signed [31:0] a, logic signed [15:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
        begin
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return s[31:0];
    endfunction

    assign init_busy = init_reg;
    assign done = done_reg;
    assign result_kind = kind_reg;
    assign normal_x = nx_reg;
    assign normal_y = ny_reg;
    assign normal_z = nz_reg;
    assign zero_length = zl_reg;

    // Corner selection for store reads and accumulator updates.
    always_comb
    begin
        sel = (state_reg == B_ACC) ? cnt_reg[2:1] : cnt_reg[1:0];
        case (sel)
            2'd0: begin idx_sel = cmd_reg.idx[0]; rng_sel = cmd_reg.in_range[0]; end
            2'd1: begin idx_sel = cmd_reg.idx[1]; rng_sel = cmd_reg.in_range[1]; end
            default: begin idx_sel = cmd_reg.idx[2]; rng_sel = cmd_reg.in_range[2]; end
        endcase
        cap_sel = cnt_reg[1:0] - 2'd1;
        case (cap_sel)
            2'd0: rng_cap = cmd_reg.in_range[0];
            2'd1: rng_cap = cmd_reg.in_range[1];
            default: rng_cap = cmd_reg.in_range[2];
        endcase
    end

    // Edge differences.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            da[i] = 33'(p_reg[0][i]) - 33'(p_reg[1][i]);
            db[i] = 33'(p_reg[1][i]) - 33'(p_reg[2][i]);
        end
    end

    // Cross product operands, one product per cycle.
    always_comb
    begin
        case (cnt_reg)
            3'd0: begin op_a = ea_reg[1]; op_b = eb_reg[2]; end
            3'd1: begin op_a = ea_reg[2]; op_b = eb_reg[1]; end
            3'd2: begin op_a = ea_reg[2]; op_b = eb_reg[0]; end
            3'd3: begin op_a = ea_reg[0]; op_b = eb_reg[2]; end
            3'd4: begin op_a = ea_reg[0]; op_b = eb_reg[1]; end
            3'd5: begin op_a = ea_reg[1]; op_b = eb_reg[0]; end
            default: begin op_a = 31'sd0; op_b = 31'sd0; end
        endcase
    end

    // Normaliser input: accumulator contents for a read (zero if the index is out of range), cross product otherwise.
    always_comb
    begin
        if (state_reg == B_READ)
        begin
            vin[0] = cmd_reg.in_range[0] ? 64'(signed'(acc_rdata[95:64])) : 64'd0;
            vin[1] = cmd_reg.in_range[0] ? 64'(signed'(acc_rdata[63:32])) : 64'd0;
            vin[2] = cmd_reg.in_range[0] ? 64'(signed'(acc_rdata[31:0])) : 64'd0;
        end
        else
        begin
            vin[0] = cross_reg[0];
            vin[1] = cross_reg[1];
            vin[2] = cross_reg[2];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (sweep_reg == LAST) state_next = B_IDLE;
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_LOAD:  state_next = B_LOAD;
                        OP_TRI:   state_next = B_FETCH;
                        OP_READ:  state_next = B_READ;
                        default:  state_next = B_CLEAR;
                    endcase
                end
            end
            B_LOAD:  state_next = B_IDLE;
            B_FETCH: if (cnt_reg == 3'd3) state_next = B_EDGE;
            B_EDGE:  state_next = B_CROSS;
            B_CROSS: if (cnt_reg == 3'd7) state_next = B_NORM;
            B_READ:  if (cnt_reg == 3'd1) state_next = B_NORM;
            B_NORM:
            begin
                if (nres.done)
                begin
                    state_next = (cmd_reg.op == OP_TRI) ? B_ACC : B_IDLE;
                end
            end
            B_ACC:   if (cnt_reg == 3'd5) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs and store ports.
    always_comb
    begin
        pop = (state_reg == B_IDLE) && cmd_valid;
        norm_start = (state_reg == B_CROSS && cnt_reg == 3'd7)
                  || (state_reg == B_READ && cnt_reg == 3'd1);
        pos_we = (state_reg == B_LOAD) && cmd_reg.in_range[0];
        pos_waddr = to_addr(cmd_reg.idx[0]);
        pos_wdata = {cmd_reg.x, cmd_reg.y, cmd_reg.z};
        pos_raddr = to_addr(idx_sel);
        acc_raddr = (state_reg == B_READ) ? to_addr(cmd_reg.idx[0]) : to_addr(idx_sel);
        acc_we = 1'b0;
        acc_waddr = to_addr(idx_sel);
        acc_wdata = {sat_add(signed'(acc_rdata[95:64]), nx_reg),
                     sat_add(signed'(acc_rdata[63:32]), ny_reg),
                     sat_add(signed'(acc_rdata[31:0]), nz_reg)};
        case (state_reg)
            B_CLEAR:
            begin
                acc_we = 1'b1;
                acc_waddr = sweep_reg;
                acc_wdata = 96'd0;
            end
            B_ACC: acc_we = cnt_reg[0] && rng_sel;
            default: acc_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            cnt_reg <= 3'd0;
            sweep_reg <= '0;
            init_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;
            done_reg <= nres.done;
            if (state_reg == B_CLEAR)
            begin
                sweep_reg <= (sweep_reg == LAST) ? '0 : sweep_reg + AW'(1);
                if (sweep_reg == LAST)
                begin
                    init_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
        end
        // Capture corner positions in the cycle after each read.
        if (state_reg == B_FETCH && cnt_reg != 3'd0)
        begin
            p_reg[cap_sel][0] <= rng_cap ? signed'(pos_rdata[95:64]) : 32'sd0;
            p_reg[cap_sel][1] <= rng_cap ? signed'(pos_rdata[63:32]) : 32'sd0;
            p_reg[cap_sel][2] <= rng_cap ? signed'(pos_rdata[31:0]) : 32'sd0;
        end
        if (state_reg == B_EDGE)
        begin
            ea_reg <= reduce_edge(da);
            eb_reg <= reduce_edge(db);
        end
        // Products alternate between the minuend and the subtrahend of each component.
        if (state_reg == B_CROSS)
        begin
            prod_reg <= op_a * op_b;
            if (cnt_reg != 3'd0 && cnt_reg != 3'd7)
            begin
                if (cnt_reg[0])
                begin
                    cross_reg[2'((cnt_reg - 3'd1) >> 1)] <= 64'(prod_reg);
                end
                else
                begin
                    cross_reg[2'((cnt_reg - 3'd1) >> 1)] <=
                        cross_reg[2'((cnt_reg - 3'd1) >> 1)] - 64'(prod_reg);
                end
            end
        end
        if (nres.done)
        begin
            kind_reg <= (cmd_reg.op == OP_READ) ? KIND_VERTEX : KIND_FACE;
            nx_reg <= nres.x;
            ny_reg <= nres.y;
            nz_reg <= nres.z;
            zl_reg <= nres.zero;
        end
    end

    mvn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    mvn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    mvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vin   (vin),
        .res   (nres)
    );

    a_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
        nres.done |-> state_reg == B_NORM) else $error("normaliser finished out of turn");
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_length) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("zero-length result with nonzero normal");
    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !done) else $error("result during clearing pass");

endmodule

// ===== sv/mesh_vertex_normals.sv =====
// Top level of the mesh vertex normal block: front end, queue and back end.
//
//  Channel   Direction  Handshake                      Fields
//  command   in         start high while busy low      func, index_a/b/c, coord_x/y/z
//  result    out        done strobe, one cycle         result_kind, normal_x/y/z, zero_length
//
// A load writes one position; a clear sweeps the accumulator store, one entry a cycle.
// Triangles and reads pass through the normaliser: up to 30 halving steps, a bit-serial
// square root (32 steps) and three divisions; a zero vector skips the root and divisions.
// After reset the accumulator store is swept to zero the same way, with busy high.
// Two commands can queue ahead of the back end; the result side cannot stall.
module mesh_vertex_normals #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [mvn_pkg::IDX_W-1:0]          index_a,
    input  logic [mvn_pkg::IDX_W-1:0]          index_b,
    input  logic [mvn_pkg::IDX_W-1:0]          index_c,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_x,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_y,
    input  logic signed [mvn_pkg::COORD_W-1:0] coord_z,
    output logic                               done,
    output logic                               result_kind,
    output logic signed [mvn_pkg::NORM_W-1:0]  normal_x,
    output logic signed [mvn_pkg::NORM_W-1:0]  normal_y,
    output logic signed [mvn_pkg::NORM_W-1:0]  normal_z,
    output logic                               zero_length
);
    import mvn_pkg::*;

    cmd_t cmd;
    logic cmd_valid, pop, init_busy;

    mvn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .hold      (init_busy),
        .func      (func),
        .index_a   (index_a),
        .index_b   (index_b),
        .index_c   (index_c),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .pop       (pop),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    mvn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .result_kind (result_kind),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .zero_length (zero_length)
    );

endmodule

// ===== bench/mesh_vertex_normals_tb.sv =====
// Self-checking testbench for the mesh vertex normal block.
module mesh_vertex_normals_tb;
    import mvn_pkg::*;

    localparam int NVERT = 1024;

    // Expected result of one triangle or read beat.
    typedef struct {
        logic                     kind;
        logic signed [15:0]       nx;
        logic signed [15:0]       ny;
        logic signed [15:0]       nz;
        logic                     zero;
    } normal_beat_t;

    // Scoreboard: predicts normals from its own copy of the mesh state.
    class normal_scoreboard;
        logic signed [31:0] pos_x[NVERT], pos_y[NVERT], pos_z[NVERT];
        logic signed [31:0] sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
        normal_beat_t pending[$];
        int mismatches;
        int checked;

        function new();
            mismatches = 0;
            checked = 0;
            for (int i = 0; i < NVERT; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
            end
        endfunction

        // Shift all magnitudes right until each is below 2^bits.
        function automatic void shrink(ref longint v[3], input int bits);
            longint unsigned m[3];
            longint unsigned mx;
            int s;
            s = 0;
            for (int i = 0; i < 3; i++)
                m[i] = v[i] < 0 ? -v[i] : v[i];
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            while ((mx >> s) >= (64'd1 << bits))
                s++;
            for (int i = 0; i < 3; i++)
                v[i] = v[i] < 0 ? -longint'(m[i] >> s) : longint'(m[i] >> s);
        endfunction

        function automatic longint unsigned int_sqrt(input longint unsigned x);
            longint unsigned r, one;
            r = 0;
            one = 64'd1 << 62;
            while (one > x)
                one >>= 2;
            while (one != 0)
            begin
                if (x >= r + one)
                begin
                    x -= r + one;
                    r = (r >> 1) + one;
                end
                else
                    r >>= 1;
                one >>= 2;
            end
            return r;
        endfunction

        // Scale a vector to Q1.14 unit length; zero vectors give zero and the flag.
        function automatic normal_beat_t unit_normal(input longint vin[3], input logic kind,
                                                    output longint n[3]);
            normal_beat_t b;
            longint v[3];
            longint unsigned m[3], s, len, q;
            v = vin;
            shrink(v, 31);
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = v[i] < 0 ? -v[i] : v[i];
                s += m[i] * m[i];
            end
            b.kind = kind;
            b.zero = (s == 0);
            for (int i = 0; i < 3; i++)
            begin
                if (s == 0)
                    n[i] = 0;
                else
                begin
                    len = int_sqrt(s);
                    q = (m[i] * UNIT_Q14 + len / 2) / len;
                    if (q > UNIT_Q14) q = UNIT_Q14;
                    n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
            b.nx = n[0][15:0];
            b.ny = n[1][15:0];
            b.nz = n[2][15:0];
            return b;
        endfunction

        function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                       input longint b);
            longint s;
            s = longint'(a) + b;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        // Note one accepted command beat.
        function void note_command(op_t op, int ia, int ib, int ic,
                                   logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
            longint ed[3], eb[3], c[3], n[3], s[3];
            int corner[3];
            case (op)
                OP_LOAD:
                begin
                    pos_x[ia] = x; pos_y[ia] = y; pos_z[ia] = z;
                end
                OP_TRI:
                begin
                    ed[0] = longint'(pos_x[ia]) - pos_x[ib];
                    ed[1] = longint'(pos_y[ia]) - pos_y[ib];
                    ed[2] = longint'(pos_z[ia]) - pos_z[ib];
                    eb[0] = longint'(pos_x[ib]) - pos_x[ic];
                    eb[1] = longint'(pos_y[ib]) - pos_y[ic];
                    eb[2] = longint'(pos_z[ib]) - pos_z[ic];
                    shrink(ed, 30);
                    shrink(eb, 30);
                    c[0] = ed[1] * eb[2] - ed[2] * eb[1];
                    c[1] = ed[2] * eb[0] - ed[0] * eb[2];
                    c[2] = ed[0] * eb[1] - ed[1] * eb[0];
                    pending.push_back(unit_normal(c, KIND_FACE, n));
                    corner[0] = ia; corner[1] = ib; corner[2] = ic;
                    foreach (corner[k])
                    begin
                        sum_x[corner[k]] = sat_add(sum_x[corner[k]], n[0]);
                        sum_y[corner[k]] = sat_add(sum_y[corner[k]], n[1]);
                        sum_z[corner[k]] = sat_add(sum_z[corner[k]], n[2]);
                    end
                end
                OP_READ:
                begin
                    s[0] = sum_x[ia]; s[1] = sum_y[ia]; s[2] = sum_z[ia];
                    pending.push_back(unit_normal(s, KIND_VERTEX, n));
                end
                default:
                    for (int i = 0; i < NVERT; i++)
                    begin
                        sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
                    end
            endcase
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(normal_beat_t got);
            normal_beat_t exp_b;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat kind=%0d n=(%0d,%0d,%0d) z=%0d",
                             got.kind, got.nx, got.ny, got.nz, got.zero);
                return;
            end
            exp_b = pending.pop_front();
            if (got.kind !== exp_b.kind || got.nx !== exp_b.nx || got.ny !== exp_b.ny ||
                got.nz !== exp_b.nz || got.zero !== exp_b.zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: beat %0d expected kind=%0d n=(%0d,%0d,%0d) z=%0d",
                             checked, exp_b.kind, exp_b.nx, exp_b.ny, exp_b.nz,
                             exp_b.zero);
                    $display("       got kind=%0d n=(%0d,%0d,%0d) z=%0d",
                             got.kind, got.nx, got.ny, got.nz, got.zero);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] func = OP_LOAD;
    logic [IDX_W-1:0] index_a = '0, index_b = '0, index_c = '0;
    logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic done;
    logic result_kind;
    logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
    logic zero_length;

    normal_scoreboard board;
    bit loaded[NVERT];
    int loaded_list[$];
    int n_tri, n_read, n_clear, n_load;

    always #1 clk = ~clk;

    mesh_vertex_normals #(.MAX_VERTICES(NVERT)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .index_a(index_a), .index_b(index_b), .index_c(index_c),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .done(done), .result_kind(result_kind), .normal_x(normal_x),
        .normal_y(normal_y), .normal_z(normal_z), .zero_length(zero_length)
    );

    // Result side: every done strobe is a beat that must be checked.
    always @(posedge clk)
    begin
        normal_beat_t got;
        if (rst_n && done)
        begin
            got.kind = result_kind;
            got.nx = normal_x;
            got.ny = normal_y;
            got.nz = normal_z;
            got.zero = zero_length;
            board.check_result(got);
        end
    end

    // Present one command and hold it until the block takes it.
    task automatic send(op_t op, int ia, int ib, int ic,
                        logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
        start <= 1'b1;
        func <= op;
        index_a <= IDX_W'(ia); index_b <= IDX_W'(ib); index_c <= IDX_W'(ic);
        coord_x <= x; coord_y <= y; coord_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(op, ia, ib, ic, x, y, z);
        if (op == OP_LOAD && !loaded[ia])
        begin
            loaded[ia] = 1'b1;
            loaded_list.push_back(ia);
        end
        case (op)
            OP_LOAD: n_load++;
            OP_TRI: n_tri++;
            OP_READ: n_read++;
            default: n_clear++;
        endcase
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 16) - 8;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_vertex();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // Stimulus: directed corner cases, then random commands, triangles most often, over a small mesh.
    initial
    begin
        int kind_sel, burst, a, b, c;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads of untouched vertices see zero sums.
        send(OP_READ, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 1023, 0, 0, 0, 0, 0);
        // Extreme positions and bit patterns.
        send(OP_LOAD, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
        send(OP_LOAD, 1, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send(OP_LOAD, 2, 0, 0, 0, 0, 32'sh80000000);
        send(OP_LOAD, 1023, 0, 0, 32'h00010000, 32'h00020000, -32'sh00030000);
        send(OP_LOAD, 512, 0, 0, -1, -1, -1);
        send(OP_LOAD, 3, 0, 0, 32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f);
        send(OP_LOAD, 5, 0, 0, 32'sh00040000, -32'sh00010000, 32'sh00000100);
        send(OP_TRI, 0, 1, 2, 0, 0, 0);
        send(OP_TRI, 1023, 512, 3, 0, 0, 0);
        // Degenerate triangles: repeated corners.
        send(OP_TRI, 0, 0, 1, 0, 0, 0);
        send(OP_TRI, 5, 5, 5, 0, 0, 0);
        send(OP_LOAD, 4, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send(OP_TRI, 512, 4, 0, 0, 0, 0);
        send(OP_READ, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 1023, 0, 0, 0, 0, 0);
        send(OP_READ, 5, 0, 0, 0, 0, 0);
        // Repeat a degenerate triangle with a repeated corner, then read, clear and read again.
        for (int i = 0; i < 4; i++)
            send(OP_TRI, 1, 1, 2, 0, 0, 0);
        send(OP_READ, 1, 0, 0, 0, 0, 0);
        send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 1, 0, 0, 0, 0, 0);

        // Random part: bursts of commands with random gaps.
        for (int i = 0; i < 750; )
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && i < 750; j++, i++)
            begin
                kind_sel = $urandom_range(0, 99);
                if (kind_sel < 25 || loaded_list.size() < 3)
                begin
                    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 31);
                    send(OP_LOAD, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         rand_coord(), rand_coord(), rand_coord());
                end
                else if (kind_sel < 70)
                begin
                    a = pick_vertex(); b = pick_vertex(); c = pick_vertex();
                    send(OP_TRI, a, b, c, $urandom, $urandom, $urandom);
                end
                else if (kind_sel < 98)
                    send(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom, $urandom, $urandom);
                else
                    send(OP_CLEAR, $urandom_range(0, 1023), 0, 0, $urandom, 0, 0);
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 200));
        end
        start <= 1'b0;

        // Drain outstanding beats, then allow the back end to settle.
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Run covered %0d loads, %0d triangles, %0d reads and %0d clears;",
                 n_load, n_tri, n_read, n_clear);
        $display("%0d result beats checked.", board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatches, %0d beats missing", board.mismatches,
                     board.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout waiting for the block");
        $display("Mismatches found");
        $finish;
    end

endmodule
